### hw/rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants, the arctangent table and the pipeline payload type for
// the Cartesian-to-polar converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

   localparam int DATA_WIDTH   = 16;
   localparam int ITERATIONS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int PHASE_WIDTH  = 32;
   localparam int MAG_WIDTH    = 16;
   localparam int ANGLE_WIDTH  = 16;

   // x grows by the CORDIC gain (< 1.65) on top of sqrt(2) * full scale
   localparam int CORDIC_WIDTH = DATA_WIDTH + FRAC_BITS + 3;
   localparam int SQ_WIDTH     = 2 * DATA_WIDTH;
   localparam int SQRT_STEPS   = DATA_WIDTH;
   localparam int ITER_STAGES  = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;
   // two front stages, the iteration stages, one output stage
   localparam int NUM_STAGES   = ITER_STAGES + 3;

   localparam logic [PHASE_WIDTH-1:0] PHASE_PI    = 32'h8000_0000;
   localparam logic [PHASE_WIDTH-1:0] PHASE_HALF  = 32'h0000_8000;
   localparam logic [MAG_WIDTH-1:0]   MAG_MAX     = '1;

   // round(atan(2^-i) * 2^31 / pi)
   localparam logic [PHASE_WIDTH-1:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   typedef struct packed {
      logic signed [CORDIC_WIDTH-1:0] x;
      logic signed [CORDIC_WIDTH-1:0] y;
      logic [PHASE_WIDTH-1:0]         z;
      logic [SQ_WIDTH-1:0]            rem;
      logic [SQ_WIDTH-1:0]            root;
      logic                           zero;
   } iter_type;

endpackage

### hw/rtl/c2p_req_if.sv
// ----------------------------------------------------------------------------
// c2p_req_if
// Input channel: one Cartesian sample per transfer.
// ----------------------------------------------------------------------------
interface c2p_req_if;
   logic                                valid;
   logic                                ready;
   logic [c2p_pkg::DATA_WIDTH-1:0]      real_part;
   logic [c2p_pkg::DATA_WIDTH-1:0]      imag_part;

   modport source (output valid, output real_part, output imag_part, input ready);
   modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

### hw/rtl/c2p_rsp_if.sv
// ----------------------------------------------------------------------------
// c2p_rsp_if
// Result channel: one polar result per transfer.
// ----------------------------------------------------------------------------
interface c2p_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [c2p_pkg::MAG_WIDTH-1:0]       magnitude;
   logic [c2p_pkg::ANGLE_WIDTH-1:0]     angle;

   modport source (output valid, output magnitude, output angle, input ready);
   modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

### hw/rtl/cartesian_to_polar.sv
// Pipeline: 2 front stages, 16 iteration stages, 1 output stage; the
//   number of iteration stages is set by the CORDIC/square-root depth.
// Throughput: one sample per cycle; a stalled result holds its stage and
//   empty stages upstream keep filling.
// Reset: synchronous, active high; clears all stage valid bits.
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Pipelined conversion of (real, imag) to rounded magnitude and atan2 angle.
// ----------------------------------------------------------------------------
module cartesian_to_polar (
   input  logic        clock,
   input  logic        reset,
   c2p_req_if.sink     req_chan,
   c2p_rsp_if.source   rsp_chan
);

   localparam int NS = c2p_pkg::NUM_STAGES;
   localparam int NI = c2p_pkg::ITER_STAGES;

   logic [NS-1:0]     stage_en;
   c2p_pkg::iter_type front_data;
   c2p_pkg::iter_type iter_data;

   c2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .stage_en  (stage_en)
   );

   c2p_front u_front (
      .clock     (clock),
      .stage_en  (stage_en[1:0]),
      .real_part (req_chan.real_part),
      .imag_part (req_chan.imag_part),
      .data_out  (front_data)
   );

   c2p_iter u_iter (
      .clock     (clock),
      .stage_en  (stage_en[NI+1:2]),
      .data_in   (front_data),
      .data_out  (iter_data)
   );

   c2p_back u_back (
      .clock     (clock),
      .stage_en  (stage_en[NS-1]),
      .data_in   (iter_data),
      .magnitude (rsp_chan.magnitude),
      .angle     (rsp_chan.angle)
   );

endmodule

### hw/rtl/c2p_ctrl.sv
// ----------------------------------------------------------------------------
// c2p_ctrl
// Valid bits and per-stage load enables. A stage loads when it is empty or
// when the stage after it loads, so bubbles are squeezed out under stall.
// ----------------------------------------------------------------------------
module c2p_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [c2p_pkg::NUM_STAGES-1:0] stage_en
);

   localparam int NS = c2p_pkg::NUM_STAGES;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;

   assign stage_en[NS-1] = !valid_ff[NS-1] || out_ready;

   for (genvar k = 0; k < NS - 1; k++) begin : g_en
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   assign valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
   for (genvar k = 1; k < NS; k++) begin : g_valid
      assign valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NS-1];

endmodule

### hw/rtl/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front
// Two stages: squares and pre-rotation into the right half plane, then the
// sum of squares that seeds the square-root recurrence.
// ----------------------------------------------------------------------------
module c2p_front (
   input  logic                            clock,
   input  logic [1:0]                      stage_en,
   input  logic [c2p_pkg::DATA_WIDTH-1:0]  real_part,
   input  logic [c2p_pkg::DATA_WIDTH-1:0]  imag_part,
   output c2p_pkg::iter_type               data_out
);

   localparam int DW = c2p_pkg::DATA_WIDTH;
   localparam int CW = c2p_pkg::CORDIC_WIDTH;
   localparam int SW = c2p_pkg::SQ_WIDTH;
   localparam int PW = c2p_pkg::PHASE_WIDTH;

   logic signed [DW-1:0] re;
   logic signed [DW-1:0] im;
   logic signed [SW-1:0] prod_re;
   logic signed [SW-1:0] prod_im;
   logic signed [CW-1:0] x_scaled;
   logic signed [CW-1:0] y_scaled;

   logic [SW-1:0]        sq_re_ff;
   logic [SW-1:0]        sq_im_ff;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic [PW-1:0]        z_ff, z_in;
   logic                 zero_ff;

   c2p_pkg::iter_type    out_ff, out_in;

   assign re       = signed'(real_part);
   assign im       = signed'(imag_part);
   assign prod_re  = SW'(re) * SW'(re);
   assign prod_im  = SW'(im) * SW'(im);
   assign x_scaled = CW'(re) <<< c2p_pkg::FRAC_BITS;
   assign y_scaled = CW'(im) <<< c2p_pkg::FRAC_BITS;

   // left half plane: turn by pi first
   always_comb begin
      if (re[DW-1]) begin
         x_in = -x_scaled;
         y_in = -y_scaled;
         z_in = c2p_pkg::PHASE_PI;
      end else begin
         x_in = x_scaled;
         y_in = y_scaled;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_re_ff <= unsigned'(prod_re);
         sq_im_ff <= unsigned'(prod_im);
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         zero_ff  <= (re == '0) && (im == '0);
      end
   end

   always_comb begin
      out_in.x    = x_ff;
      out_in.y    = y_ff;
      out_in.z    = z_ff;
      out_in.rem  = sq_re_ff + sq_im_ff;
      out_in.root = '0;
      out_in.zero = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         out_ff <= out_in;
      end
   end

   assign data_out = out_ff;

endmodule

### hw/rtl/c2p_iter.sv
// ----------------------------------------------------------------------------
// c2p_iter
// Iteration pipeline: each stage does one CORDIC vectoring micro-rotation
// and one digit of the restoring square root, side by side.
// ----------------------------------------------------------------------------
module c2p_iter (
   input  logic                             clock,
   input  logic [c2p_pkg::ITER_STAGES-1:0]  stage_en,
   input  c2p_pkg::iter_type                data_in,
   output c2p_pkg::iter_type                data_out
);

   localparam int NI = c2p_pkg::ITER_STAGES;
   localparam int SW = c2p_pkg::SQ_WIDTH;
   localparam int CW = c2p_pkg::CORDIC_WIDTH;

   c2p_pkg::iter_type stage_ff [NI];
   c2p_pkg::iter_type stage_in [NI];
   c2p_pkg::iter_type stage_src [NI];

   for (genvar k = 0; k < NI; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign stage_src[k] = data_in;
      end else begin : g_next
         assign stage_src[k] = stage_ff[k-1];
      end

      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic [SW-1:0]        trial;

      assign xs = stage_src[k].x >>> k;
      assign ys = stage_src[k].y >>> k;

      if (k < c2p_pkg::SQRT_STEPS) begin : g_sqrt
         localparam logic [SW-1:0] SQ_BIT = SW'(1) << (2 * (c2p_pkg::SQRT_STEPS - 1 - k));
         assign trial = stage_src[k].root + SQ_BIT;

         always_comb begin
            if (stage_src[k].rem >= trial) begin
               stage_in[k].rem  = stage_src[k].rem - trial;
               stage_in[k].root = (stage_src[k].root >> 1) + SQ_BIT;
            end else begin
               stage_in[k].rem  = stage_src[k].rem;
               stage_in[k].root = stage_src[k].root >> 1;
            end
         end
      end else begin : g_sqrt_pass
         assign trial            = stage_src[k].root;
         assign stage_in[k].rem  = stage_src[k].rem;
         assign stage_in[k].root = trial;
      end

      if (k < c2p_pkg::ITERATIONS) begin : g_rot
         always_comb begin
            if (!stage_src[k].y[CW-1]) begin
               stage_in[k].x = stage_src[k].x + ys;
               stage_in[k].y = stage_src[k].y - xs;
               stage_in[k].z = stage_src[k].z + c2p_pkg::ATAN_TAB[k];
            end else begin
               stage_in[k].x = stage_src[k].x - ys;
               stage_in[k].y = stage_src[k].y + xs;
               stage_in[k].z = stage_src[k].z - c2p_pkg::ATAN_TAB[k];
            end
         end
      end else begin : g_rot_pass
         assign stage_in[k].x = stage_src[k].x ^ (xs & '0);
         assign stage_in[k].y = stage_src[k].y ^ (ys & '0);
         assign stage_in[k].z = stage_src[k].z;
      end

      assign stage_in[k].zero = stage_src[k].zero;

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign data_out = stage_ff[NI-1];

endmodule

### hw/rtl/c2p_back.sv
// ----------------------------------------------------------------------------
// c2p_back
// Output stage: rounds the square root to nearest, saturates it, and rounds
// the 32-bit phase to the 16-bit angle (zero for a zero input).
// ----------------------------------------------------------------------------
module c2p_back (
   input  logic                             clock,
   input  logic                             stage_en,
   input  c2p_pkg::iter_type                data_in,
   output logic [c2p_pkg::MAG_WIDTH-1:0]    magnitude,
   output logic [c2p_pkg::ANGLE_WIDTH-1:0]  angle
);

   localparam int SW = c2p_pkg::SQ_WIDTH;
   localparam int PW = c2p_pkg::PHASE_WIDTH;
   localparam int MW = c2p_pkg::MAG_WIDTH;
   localparam int AW = c2p_pkg::ANGLE_WIDTH;

   logic [SW:0]    mag_full;
   logic [PW-1:0]  phase_rnd;
   logic [MW-1:0]  mag_ff, mag_in;
   logic [AW-1:0]  angle_ff, angle_in;

   // remainder above the root means the true root is past k + 0.5
   assign mag_full  = {1'b0, data_in.root} + (SW+1)'(data_in.rem > data_in.root);
   assign phase_rnd = data_in.z + c2p_pkg::PHASE_HALF;

   always_comb begin
      if (mag_full > (SW+1)'(c2p_pkg::MAG_MAX)) begin
         mag_in = c2p_pkg::MAG_MAX;
      end else begin
         mag_in = mag_full[MW-1:0];
      end
      if (data_in.zero) begin
         angle_in = '0;
      end else begin
         angle_in = phase_rnd[PW-1 -: AW];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         mag_ff   <= mag_in;
         angle_ff <= angle_in;
      end
   end

   assign magnitude = mag_ff;
   assign angle     = angle_ff;

endmodule
